[sv/smpq_pkg.sv]
// shared types and constants of the stable max priority queue
package smpq_pkg;

   localparam int CAPACITY           = 16;
   localparam int TAG_WIDTH          = 16;
   localparam int PRIORITY_WIDTH     = 8;
   localparam int COUNT_WIDTH        = $clog2(CAPACITY + 1);
   localparam int COUNT_FIELD_WIDTH  = 5;
   localparam int OP_WIDTH           = 2;
   localparam int REQ_DATA_WIDTH     = ((TAG_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELDS_WIDTH   = 1 + TAG_WIDTH + PRIORITY_WIDTH + 1 +
                                       COUNT_FIELD_WIDTH + 1 + 1;
   localparam int RSP_DATA_WIDTH     = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_INSERT  = 2'd0,
      OP_EXTRACT = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef struct packed {
      logic [TAG_WIDTH-1:0]      tag;
      logic [PRIORITY_WIDTH-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic      ins;
      logic      ext;
      logic      clr;
      entry_type new_entry;
   } cmd_type;

   typedef struct packed {
      logic      valid;
      logic      yield;
      entry_type entry;
   } link_type;

endpackage

[sv/smpq_cell.sv]
// one slot of the sorted entry chain
module smpq_cell (
   input  logic                clock,
   input  logic                reset,
   input  smpq_pkg::cmd_type   cmd,
   input  smpq_pkg::link_type  prev_link,
   input  smpq_pkg::link_type  next_link,
   output smpq_pkg::link_type  own_link
);
   import smpq_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      yield;

   // slot gives way when empty or holding a strictly lower priority
   assign yield = !valid_ff || (entry_ff.prio < cmd.new_entry.prio);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (cmd.clr) begin
         valid_in = 1'b0;
      end else if (cmd.ext) begin
         valid_in = next_link.valid;
         entry_in = next_link.entry;
      end else if (cmd.ins && yield) begin
         if (prev_link.yield) begin
            valid_in = prev_link.valid;
            entry_in = prev_link.entry;
         end else begin
            valid_in = 1'b1;
            entry_in = cmd.new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign own_link.valid = valid_ff;
   assign own_link.yield = yield;
   assign own_link.entry = entry_ff;

endmodule

[sv/stable_max_priority_queue_unit.sv]
// top level of the stable max priority queue
//
// requests enter on req_ (tvalid/tready/tdata/tuser), results leave on rsp_.
// req_tuser carries the operation: insert, extract highest priority, clear.
// entries sit in a chain of slots kept sorted by priority, highest at the
// head; equal priorities stay in arrival order, so an extract always takes
// the head slot and every slot shifts one place toward it.
// an insert ripples the new entry into place: every slot behind the insert
// point shifts one place back in the same cycle.
// each request yields exactly one result, registered and presented in the cycle
// after the request is taken; a new request is taken every cycle while the result
// register is empty or being drained, so sustained rate is one request per
// cycle.
// when rsp_tready is low the result holds and req_tready drops until it is
// taken.
// reset empties the queue and the result register; no clearing pass is run.
module stable_max_priority_queue_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // item_tag, priority_req
   input  logic [smpq_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // operation
   input  logic [smpq_pkg::OP_WIDTH-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_valid, out_tag, out_priority, insert_dropped, entry_count,
   // is_empty, is_full, zero fill
   output logic [smpq_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import smpq_pkg::*;

   link_type  links [CAPACITY];
   link_type  head_link;
   link_type  tail_link;
   cmd_type   cmd;
   op_type    op;
   logic      accept;
   logic      full;
   logic      empty;

   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic                      out_valid;
   entry_type                 out_entry;
   logic                      dropped;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign full       = (count_ff == COUNT_WIDTH'(CAPACITY));
   assign empty      = (count_ff == '0);

   always_comb begin
      cmd.ins       = 1'b0;
      cmd.ext       = 1'b0;
      cmd.clr       = 1'b0;
      cmd.new_entry.tag  = req_tdata[TAG_WIDTH-1:0];
      cmd.new_entry.prio = req_tdata[TAG_WIDTH+PRIORITY_WIDTH-1:TAG_WIDTH];
      dropped       = 1'b0;
      count_in      = count_ff;
      if (accept) begin
         unique case (op)
            OP_INSERT: begin
               if (full) begin
                  dropped = 1'b1;
               end else begin
                  cmd.ins  = 1'b1;
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
            end
            OP_EXTRACT: begin
               if (!empty) begin
                  cmd.ext  = 1'b1;
                  count_in = count_ff - COUNT_WIDTH'(1);
               end
            end
            OP_CLEAR: begin
               cmd.clr  = 1'b1;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign head_link.valid = 1'b0;
   assign head_link.yield = 1'b0;
   assign head_link.entry = '0;
   assign tail_link.valid = 1'b0;
   assign tail_link.yield = 1'b0;
   assign tail_link.entry = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      smpq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .prev_link ((i == 0) ? head_link : links[(i == 0) ? 0 : i-1]),
         .next_link ((i == CAPACITY-1) ? tail_link :
                     links[(i == CAPACITY-1) ? i : i+1]),
         .own_link  (links[i])
      );
   end

   assign out_valid = cmd.ext;
   assign out_entry = cmd.ext ? links[0].entry : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_WIDTH'({
            (count_in == COUNT_WIDTH'(CAPACITY)),
            (count_in == '0),
            COUNT_FIELD_WIDTH'(count_in),
            dropped,
            out_entry.prio,
            out_entry.tag,
            out_valid
         });
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[sim/stable_max_priority_queue_unit_test.sv]
// testbench for the stable max priority queue: directed and random requests
`timescale 1ns / 100ps

module stable_max_priority_queue_unit_test;
   import smpq_pkg::*;

   localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;
   localparam int PRIO_LSB  = TAG_WIDTH + 1;
   localparam int DROP_BIT  = TAG_WIDTH + PRIORITY_WIDTH + 1;
   localparam int COUNT_LSB = DROP_BIT + 1;
   localparam int EMPTY_BIT = COUNT_LSB + COUNT_FIELD_WIDTH;
   localparam int FULL_BIT  = EMPTY_BIT + 1;

   typedef struct packed {
      logic                         hit;
      logic [TAG_WIDTH-1:0]         tag;
      logic [PRIORITY_WIDTH-1:0]    prio;
      logic                         dropped;
      logic [COUNT_FIELD_WIDTH-1:0] count;
      logic                         empty;
      logic                         full;
   } outcome_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic [OP_WIDTH-1:0]       req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   // predictor state
   logic [TAG_WIDTH-1:0]      held_tag [CAPACITY];
   logic [PRIORITY_WIDTH-1:0] held_prio [CAPACITY];
   int                        held_n;

   outcome_type  outcome_q[$];
   int           fault_count;
   bit           req_idle_on;
   bit           rsp_stall_on;
   int           stall_left;

   stable_max_priority_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("stable_max_priority_queue_unit_test NOT OK");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic outcome_type apply_queue_op(logic [OP_WIDTH-1:0] op,
                                                  logic [TAG_WIDTH-1:0] tag,
                                                  logic [PRIORITY_WIDTH-1:0] prio);
      outcome_type  o;
      int           best;
      o = '0;
      case (op)
         OP_INSERT: begin
            if (held_n >= CAPACITY) begin
               o.dropped = 1'b1;
            end else begin
               held_tag[held_n]  = tag;
               held_prio[held_n] = prio;
               held_n++;
            end
         end
         OP_EXTRACT: begin
            if (held_n != 0) begin
               best = 0;
               // strict compare keeps the earliest of equal priorities
               for (int i = 1; i < held_n; i++)
                  if (held_prio[i] > held_prio[best]) best = i;
               o.hit  = 1'b1;
               o.tag  = held_tag[best];
               o.prio = held_prio[best];
               for (int i = best; i + 1 < held_n; i++) begin
                  held_tag[i]  = held_tag[i + 1];
                  held_prio[i] = held_prio[i + 1];
               end
               held_n--;
            end
         end
         OP_CLEAR: held_n = 0;
         default: ;
      endcase
      o.count = COUNT_FIELD_WIDTH'(held_n);
      o.empty = (held_n == 0);
      o.full  = (held_n == CAPACITY);
      return o;
   endfunction

   function automatic outcome_type decode_result(logic [RSP_DATA_WIDTH-1:0] d);
      outcome_type o;
      o.hit     = d[0];
      o.tag     = d[1 +: TAG_WIDTH];
      o.prio    = d[PRIO_LSB +: PRIORITY_WIDTH];
      o.dropped = d[DROP_BIT];
      o.count   = d[COUNT_LSB +: COUNT_FIELD_WIDTH];
      o.empty   = d[EMPTY_BIT];
      o.full    = d[FULL_BIT];
      return o;
   endfunction

   task automatic report_fault(string what, logic [31:0] got, logic [31:0] want);
      fault_count++;
      if (fault_count <= 10)
         $display("%0t: %s mismatch: got %0h expected %0h", $realtime, what, got, want);
   endtask

   // sender: entered just after a rising edge, leaves tvalid high after acceptance
   task automatic send_request(logic [OP_WIDTH-1:0] op, logic [TAG_WIDTH-1:0] tag,
                               logic [PRIORITY_WIDTH-1:0] prio);
      int gap;
      gap = req_idle_on ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = '0;
      req_tdata[TAG_WIDTH-1:0] = tag;
      req_tdata[TAG_WIDTH +: PRIORITY_WIDTH] = prio;
      req_tuser  = op;
      do @(posedge clock); while (!req_tready);
      outcome_q.push_back(apply_queue_op(op, tag, prio));
   endtask

   // result sink with random stalls
   initial begin
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0 && rsp_stall_on) stall_left = pick_gap();
         rsp_tready = (stall_left == 0);
         if (stall_left != 0) stall_left--;
      end
   end

   always @(posedge clock) begin : check_results
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = decode_result(rsp_tdata);
         if (outcome_q.size() == 0) begin
            report_fault("unexpected result", rsp_tdata[31:0], '0);
         end else begin
            want = outcome_q.pop_front();
            if (got.hit !== want.hit)
               report_fault("out_valid", 32'(got.hit), 32'(want.hit));
            if (got.tag !== want.tag)
               report_fault("out_tag", 32'(got.tag), 32'(want.tag));
            if (got.prio !== want.prio)
               report_fault("out_priority", 32'(got.prio), 32'(want.prio));
            if (got.dropped !== want.dropped)
               report_fault("insert_dropped", 32'(got.dropped), 32'(want.dropped));
            if (got.count !== want.count)
               report_fault("entry_count", 32'(got.count), 32'(want.count));
            if (got.empty !== want.empty)
               report_fault("is_empty", 32'(got.empty), 32'(want.empty));
            if (got.full !== want.full)
               report_fault("is_full", 32'(got.full), 32'(want.full));
         end
      end
   end

   task automatic test_empty_queue();
      send_request(OP_EXTRACT, 16'h0000, 8'h00);
      send_request(OP_UNUSED, 16'hFFFF, 8'hFF);
      send_request(OP_CLEAR, 16'hFFFF, 8'hFF);
      send_request(OP_EXTRACT, 16'hFFFF, 8'hFF);
   endtask

   task automatic test_stable_order();
      send_request(OP_INSERT, 16'h0000, 8'd7);
      send_request(OP_INSERT, 16'hFFFF, 8'd255);
      send_request(OP_INSERT, 16'h5A5A, 8'd7);
      send_request(OP_INSERT, 16'hA5A5, 8'd0);
      send_request(OP_UNUSED, 16'h1234, 8'h80);
      send_request(OP_EXTRACT, 16'h0000, 8'h00);
      send_request(OP_EXTRACT, 16'h0000, 8'h00);
   endtask

   task automatic test_full_queue();
      int fill;
      fill = CAPACITY - held_n;
      // priorities drawn only from 2 and 3 so ties reach deep slots
      repeat (fill)
         send_request(OP_INSERT, 16'($urandom), 8'($urandom_range(2, 3)));
      send_request(OP_INSERT, 16'hFFFF, 8'hFF);
      send_request(OP_EXTRACT, 16'h0000, 8'h00);
      send_request(OP_INSERT, 16'hC3C3, 8'd3);
      send_request(OP_CLEAR, 16'h0000, 8'h00);
   endtask

   task automatic test_random_traffic(int phases, int per_phase);
      int ins_pct;
      int clr_pct;
      int prio_top;
      int r;
      logic [OP_WIDTH-1:0] op;
      for (int p = 0; p < phases; p++) begin
         req_idle_on  = (p % 4 != 3);
         rsp_stall_on = (p % 5 != 4);
         case ($urandom_range(0, 3))
            0: ins_pct = 80;
            1: ins_pct = 55;
            2: ins_pct = 30;
            default: ins_pct = 65;
         endcase
         clr_pct  = (ins_pct >= 65) ? 0 : 2;
         prio_top = $urandom_range(0, 1) ? 255 : 3;
         for (int k = 0; k < per_phase; k++) begin
            r = $urandom_range(0, 99);
            if (p % 6 == 5) op = OP_WIDTH'($urandom_range(0, 3));
            else if (r < 1) op = OP_UNUSED;
            else if (r < 1 + clr_pct) op = OP_CLEAR;
            else if (r < 1 + clr_pct + ins_pct) op = OP_INSERT;
            else op = OP_EXTRACT;
            send_request(op, 16'($urandom), 8'($urandom_range(0, prio_top)));
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      held_n      = 0;
      fault_count = 0;
      req_idle_on = 1'b0;
      rsp_stall_on = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_stable_order();
      req_idle_on  = 1'b1;
      rsp_stall_on = 1'b1;
      test_full_queue();
      test_random_traffic(12, 75);

      @(negedge clock);
      req_tvalid = 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (fault_count == 0)
         $display("stable_max_priority_queue_unit_test OK");
      else
         $display("stable_max_priority_queue_unit_test NOT OK");
      $finish;
   end

endmodule
